// ----- rtl/ghst_pkg.sv -----
package ghst_pkg;

  // Table geometry. The 9-bit live count caps the slot count at 511.
  localparam int SLOTS    = 256;
  localparam int IDX_W    = $clog2(SLOTS);
  localparam int TOP_W    = $clog2(SLOTS + 1);
  localparam int GEN_W    = 24;
  localparam int LOW_W    = 24;
  localparam int HANDLE_W = GEN_W + LOW_W;
  localparam int COUNT_W  = 9;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 3'd0,
    FUNC_DESTROY = 3'd1,
    FUNC_RELEASE = 3'd2,
    FUNC_ADMIT   = 3'd3,
    FUNC_RESOLVE = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    PH_FREE    = 2'd0,
    PH_PENDING = 2'd1,
    PH_LIVE    = 2'd2,
    PH_DOOMED  = 2'd3
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  // Per-slot record: generation and phase.
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    phase_e           phase;
  } slot_ent_t;

  // Free stack record: slot index plus the generation it will be handed out with.
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] idx;
  } fs_ent_t;

endpackage

// ----- rtl/ghst_ram.sv -----
module ghst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the contents before a same-edge write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/generational_handle_slot_table.sv -----
// Generational handle slot table, 256 slots. A request (func_i, handle_i,
// allow_pending_i) is taken at any rising edge with start_i high; busy_o is
// never raised, so one request can be issued every cycle. Each request gives
// exactly one result: done_o is raised after the request has passed the
// request and result registers, and status_o, handle_out_o and live_count_o
// are valid only while done_o is raised for it. The receiver cannot stall the
// table, so the result must be captured when done_o is seen. Results come
// back in request order. Slot records (generation and phase) and the LIFO
// free stack live in two RAMs with registered reads; each request reads its
// slot at the accepting edge, and the one request in flight before it is
// covered by a one-deep write bypass, so back-to-back requests on the same
// slot behave as if issued one at a time. Slot records not yet written since
// reset read as generation zero, free, through per-slot valid flops; the free
// stack uses a low-water mark instead. No clearing pass is needed, so the
// table accepts requests right out of reset.
module generational_handle_slot_table
  import ghst_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [HANDLE_W-1:0] handle_i,
  input  logic                allow_pending_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [COUNT_W-1:0]  live_count_o
);

  // ---------------------------------------------------------------------------
  // Request register
  // ---------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [FUNC_W-1:0]   func_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                pend_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      func_q   <= func_i;
      handle_q <= handle_i;
      pend_q   <= allow_pending_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Slot record RAM, read at the accepting edge with the incoming index
  // ---------------------------------------------------------------------------
  logic                   ph_we;
  logic [IDX_W-1:0]       ph_waddr;
  slot_ent_t              ph_wdata;
  logic [IDX_W-1:0]       ph_raddr;
  logic [$bits(slot_ent_t)-1:0] ph_rdata;

  // index = low field minus one; out-of-range values are rejected later
  assign ph_raddr = IDX_W'(handle_i[LOW_W-1:0] - LOW_W'(1));

  ghst_ram #(
    .WIDTH ($bits(slot_ent_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ph_we),
    .waddr_i (ph_waddr),
    .wdata_i (ph_wdata),
    .raddr_i (ph_raddr),
    .rdata_o (ph_rdata)
  );

  // write bypass for the request just ahead, plus written-since-reset flags
  logic             ph_we_q;
  logic [IDX_W-1:0] ph_waddr_q;
  slot_ent_t        ph_wdata_q;
  logic [SLOTS-1:0] ph_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_we_q  <= 1'b0;
      ph_vld_q <= '0;
    end else begin
      ph_we_q <= ph_we;
      if (ph_we) begin
        ph_vld_q[ph_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ph_waddr_q <= ph_waddr;
    ph_wdata_q <= ph_wdata;
  end

  // ---------------------------------------------------------------------------
  // Free stack RAM, always read at the next top-of-stack position
  // ---------------------------------------------------------------------------
  logic [TOP_W-1:0]        top_q, top_d;
  logic [TOP_W-1:0]        low_q, low_d;   // lowest top seen since reset
  logic                    fs_we;
  logic [IDX_W-1:0]        fs_waddr;
  fs_ent_t                 fs_wdata;
  logic [IDX_W-1:0]        fs_raddr;
  logic [$bits(fs_ent_t)-1:0] fs_rdata;
  logic                    push_q;
  fs_ent_t                 push_data_q;

  assign fs_raddr = IDX_W'(top_d - TOP_W'(1));

  ghst_ram #(
    .WIDTH ($bits(fs_ent_t)),
    .DEPTH (SLOTS)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  always_ff @(posedge clk_i) begin
    push_data_q <= fs_wdata;
  end

  // ---------------------------------------------------------------------------
  // Count and stack pointer registers
  // ---------------------------------------------------------------------------
  logic [COUNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= TOP_W'(SLOTS);
      low_q  <= TOP_W'(SLOTS);
      cnt_q  <= '0;
      push_q <= 1'b0;
    end else begin
      top_q  <= top_d;
      low_q  <= low_d;
      cnt_q  <= cnt_d;
      push_q <= fs_we;
    end
  end

  assign low_d = (top_d < low_q) ? top_d : low_q;

  // ---------------------------------------------------------------------------
  // Single-pass request logic
  // ---------------------------------------------------------------------------
  logic [LOW_W-1:0]   s_low;
  logic [GEN_W-1:0]   s_gen;
  logic [IDX_W-1:0]   s_idx;
  logic               idx_ok;
  slot_ent_t          ent;
  logic               located;
  logic               res_any;
  logic               res_req;
  logic [TOP_W-1:0]   pos;
  fs_ent_t            fs_top;
  status_e            status_d;
  logic [HANDLE_W-1:0] hout_d;

  always_comb begin
    s_low  = handle_q[LOW_W-1:0];
    s_gen  = handle_q[HANDLE_W-1:LOW_W];
    s_idx  = IDX_W'(s_low - LOW_W'(1));
    idx_ok = (s_low != '0) && (s_low <= LOW_W'(SLOTS));

    // slot record: bypass, then RAM if written since reset, else reset value
    if (ph_we_q && (ph_waddr_q == s_idx)) begin
      ent = ph_wdata_q;
    end else if (ph_vld_q[s_idx]) begin
      ent = slot_ent_t'(ph_rdata);
    end else begin
      ent = '{gen: '0, phase: PH_FREE};
    end

    located = idx_ok && (ent.gen == s_gen) && (ent.phase != PH_FREE);
    res_any = located && (ent.phase != PH_DOOMED);
    res_req = res_any && ((ent.phase != PH_PENDING) || pend_q);

    // top of free stack: a push at the last edge went to exactly this spot;
    // positions below the low-water mark still hold their reset contents
    pos = top_q - TOP_W'(1);
    if (push_q) begin
      fs_top = push_data_q;
    end else if (pos < low_q) begin
      fs_top = '{gen: '0, idx: IDX_W'(SLOTS - 1) - pos[IDX_W-1:0]};
    end else begin
      fs_top = fs_ent_t'(fs_rdata);
    end

    ph_we    = 1'b0;
    ph_waddr = s_idx;
    ph_wdata = ent;
    fs_we    = 1'b0;
    fs_waddr = top_q[IDX_W-1:0];
    fs_wdata = '{gen: ent.gen + GEN_W'(1), idx: s_idx};
    top_d    = top_q;
    cnt_d    = cnt_q;
    status_d = ST_BAD;
    hout_d   = '0;

    if (s1_valid_q) begin
      case (func_e'(func_q))
        FUNC_ALLOC: begin
          if (top_q == '0) begin
            status_d = ST_FULL;
          end else begin
            top_d    = top_q - TOP_W'(1);
            ph_we    = 1'b1;
            ph_waddr = fs_top.idx;
            ph_wdata = '{gen: fs_top.gen, phase: PH_PENDING};
            hout_d   = {fs_top.gen, LOW_W'(fs_top.idx) + LOW_W'(1)};
            status_d = ST_OK;
          end
        end
        FUNC_DESTROY: begin
          if (res_any) begin
            if ((ent.phase == PH_LIVE) && (cnt_q != '0)) begin
              cnt_d = cnt_q - COUNT_W'(1);
            end
            ph_we    = 1'b1;
            ph_wdata = '{gen: ent.gen, phase: PH_DOOMED};
            status_d = ST_OK;
            hout_d   = handle_q;
          end
        end
        FUNC_RELEASE: begin
          if (located) begin
            if ((ent.phase == PH_LIVE) && (cnt_q != '0)) begin
              cnt_d = cnt_q - COUNT_W'(1);
            end
            ph_we    = 1'b1;
            ph_wdata = '{gen: ent.gen + GEN_W'(1), phase: PH_FREE};
            if (top_q < TOP_W'(SLOTS)) begin
              fs_we = 1'b1;
              top_d = top_q + TOP_W'(1);
            end
            status_d = ST_OK;
            hout_d   = handle_q;
          end
        end
        FUNC_ADMIT: begin
          if (res_any) begin
            if (ent.phase == PH_PENDING) begin
              ph_we    = 1'b1;
              ph_wdata = '{gen: ent.gen, phase: PH_LIVE};
              if (cnt_q < COUNT_W'(SLOTS)) begin
                cnt_d = cnt_q + COUNT_W'(1);
              end
            end
            status_d = ST_OK;
            hout_d   = handle_q;
          end
        end
        FUNC_RESOLVE: begin
          if (res_req) begin
            status_d = ST_OK;
            hout_d   = handle_q;
          end
        end
        default: begin
          status_d = ST_BAD;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                done_q;
  status_e             status_q;
  logic [HANDLE_W-1:0] hout_q;
  logic [COUNT_W-1:0]  live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hout_q   <= hout_d;
    live_q   <= cnt_d;
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign handle_out_o = hout_q;
  assign live_count_o = live_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_top_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_W'(SLOTS))
    else $error("free stack pointer beyond slot count");

  a_low_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q <= top_q)
    else $error("low-water mark above stack pointer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= (COUNT_W + 1)'(SLOTS) - (COUNT_W + 1)'(top_q))
    else $error("live count exceeds allocated slots");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (handle_out_o == '0))
    else $error("failed request returned a handle");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (status_d == ST_FULL)) |-> (top_q == '0))
    else $error("table full reported with free slots");

endmodule

// ----- test/generational_handle_slot_table_tb.sv -----
`timescale 1ns / 1ps

// Slot table testbench. A shadow copy of the table (generations, phases,
// LIFO free stack, live count) predicts the answer to every request at the
// edge that accepts it. A checker compares each done_o strobe against the
// oldest predicted answer, field by field.
module generational_handle_slot_table_tb;
  import ghst_pkg::*;

  // Func codes past the defined set; the table must refuse them.
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

  localparam int STALL_LIMIT  = 2000; // cycles with no request and no answer
  localparam int TAIL_CYCLES  = 8;    // idle margin after the last drain
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    status_e              status;
    logic [HANDLE_W-1:0]  handle;
    logic [COUNT_W-1:0]   count;
  } slot_reply_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [FUNC_W-1:0]   func_i;
  logic [HANDLE_W-1:0] handle_i;
  logic                allow_pending_i;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [HANDLE_W-1:0] handle_out_o;
  logic [COUNT_W-1:0]  live_count_o;

  generational_handle_slot_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .func_i          (func_i),
    .handle_i        (handle_i),
    .allow_pending_i (allow_pending_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .handle_out_o    (handle_out_o),
    .live_count_o    (live_count_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow table
  // ---------------------------------------------------------------------------
  logic [GEN_W-1:0] slot_gen   [SLOTS];
  phase_e           slot_state [SLOTS];
  logic [IDX_W-1:0] free_list  [SLOTS];
  logic [TOP_W-1:0] free_depth;
  logic [COUNT_W-1:0] live_slots;

  slot_reply_t answers_due[$];   // predicted answers, oldest first
  int unsigned slot_order[SLOTS]; // scratch permutation for sweeps

  int mismatch_count = 0;
  int func_seen[8];
  int ok_seen, full_seen, bad_seen;
  bit no_gaps = 1'b0;

  function automatic logic [HANDLE_W-1:0] make_handle(input int unsigned idx,
                                                      input logic [GEN_W-1:0] g);
    return {g, LOW_W'(idx + 1)};
  endfunction

  function automatic void reset_table_model();
    for (int i = 0; i < SLOTS; i++) begin
      slot_gen[i]   = '0;
      slot_state[i] = PH_FREE;
      free_list[i]  = IDX_W'(SLOTS - 1 - i); // slot 0 pops first
    end
    free_depth = TOP_W'(SLOTS);
    live_slots = '0;
  endfunction

  // Applies one request to the shadow table and returns the answer it owes.
  function automatic slot_reply_t predict_slot_request(input logic [FUNC_W-1:0] fn,
                                                       input logic [HANDLE_W-1:0] h,
                                                       input logic ap);
    slot_reply_t      r;
    logic [LOW_W-1:0] low;
    int unsigned      idx;
    bit               located;
    bit               usable;
    low = h[LOW_W-1:0];
    idx = 0;
    // located: index in range, generation matches, slot not free
    located = (low != '0) && (low <= SLOTS);
    if (located) begin
      idx = low - 1;
      located = (slot_gen[idx] == h[HANDLE_W-1:LOW_W]) && (slot_state[idx] != PH_FREE);
    end
    // usable: located and not doomed (pending still allowed here)
    usable = located && (slot_state[idx] != PH_DOOMED);
    r.status = ST_BAD;
    r.handle = '0;
    case (fn)
      FUNC_ALLOC: begin
        if (free_depth == 0) begin
          r.status = ST_FULL;
        end else begin
          free_depth--;
          idx = free_list[free_depth];
          slot_state[idx] = PH_PENDING;
          r.status = ST_OK;
          r.handle = make_handle(idx, slot_gen[idx]);
        end
      end
      FUNC_DESTROY: begin
        if (usable) begin
          if (slot_state[idx] == PH_LIVE && live_slots != 0) live_slots--;
          slot_state[idx] = PH_DOOMED;
          r.status = ST_OK;
          r.handle = h;
        end
      end
      FUNC_RELEASE: begin
        // doomed slots may be released as well
        if (located) begin
          if (slot_state[idx] == PH_LIVE && live_slots != 0) live_slots--;
          slot_state[idx] = PH_FREE;
          slot_gen[idx] = slot_gen[idx] + 1'b1; // wraps at 2^24
          if (free_depth < SLOTS) begin
            free_list[free_depth] = IDX_W'(idx);
            free_depth++;
          end
          r.status = ST_OK;
          r.handle = h;
        end
      end
      FUNC_ADMIT: begin
        // already live: ok, no change
        if (usable) begin
          if (slot_state[idx] == PH_PENDING) begin
            slot_state[idx] = PH_LIVE;
            if (live_slots < SLOTS) live_slots++;
          end
          r.status = ST_OK;
          r.handle = h;
        end
      end
      FUNC_RESOLVE: begin
        if (usable && (slot_state[idx] != PH_PENDING || ap)) begin
          r.status = ST_OK;
          r.handle = h;
        end
      end
      default: ; // spare codes: refused, nothing changes
    endcase
    r.count = live_slots;
    func_seen[fn]++;
    case (r.status)
      ST_OK:   ok_seen++;
      ST_FULL: full_seen++;
      default: bad_seen++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Answer checker and watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_answers
    slot_reply_t want;
    if (rst_ni && done_o) begin
      if (answers_due.size() == 0) begin
        $error("answer with no request outstanding: status %0d handle %h count %0d",
               status_o, handle_out_o, live_count_o);
        mismatch_count++;
      end else begin
        want = answers_due.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatch_count++;
        end
        if (handle_out_o !== want.handle) begin
          $error("handle_out: expected %h, got %h", want.handle, handle_out_o);
          mismatch_count++;
        end
        if (live_count_o !== want.count) begin
          $error("live_count: expected %0d, got %0d", want.count, live_count_o);
          mismatch_count++;
        end
      end
    end
  end

  int stall_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Random idle after a request: mostly none, sometimes short, rarely long.
  // Fields carry junk while start_i is low.
  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    if (n != 0) begin
      start_i         <= 1'b0;
      func_i          <= FUNC_W'($urandom);
      handle_i        <= HANDLE_W'({$urandom, $urandom});
      allow_pending_i <= 1'(($urandom));
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Issues one request, waits for acceptance, predicts its answer.
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [HANDLE_W-1:0] h,
                              input logic ap);
    start_i         <= 1'b1;
    func_i          <= fn;
    handle_i        <= h;
    allow_pending_i <= ap;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    answers_due.push_back(predict_slot_request(fn, h, ap));
    sender_gap();
  endtask

  // Sender holds off until every outstanding answer is back.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat ($urandom_range(1, 4)) @(posedge clk_i);
  endtask

  function automatic void shuffle_order();
    int unsigned j;
    int unsigned t;
    for (int i = 0; i < SLOTS; i++) slot_order[i] = i;
    for (int i = SLOTS - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = slot_order[i];
      slot_order[i] = slot_order[j];
      slot_order[j] = t;
    end
  endfunction

  // Handle mix: mostly handles of slots in use, then stale generations,
  // possibly-free slots, none, out-of-range indexes and raw noise.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned r;
    int unsigned slot;
    int unsigned s;
    r = $urandom_range(99);
    slot = $urandom_range(SLOTS - 1);
    if (r < 65) begin
      for (int k = 0; k < SLOTS; k++) begin
        s = (slot + k) % SLOTS;
        if (slot_state[s] != PH_FREE) return make_handle(s, slot_gen[s]);
      end
      return make_handle(slot, slot_gen[slot]);
    end
    if (r < 78) return make_handle(slot, slot_gen[slot] - 1'b1);
    if (r < 86) return make_handle(slot, slot_gen[slot]);
    if (r < 90) return '0;
    if (r < 95) return {GEN_W'($urandom), LOW_W'($urandom_range(SLOTS + 1, (1 << LOW_W) - 1))};
    return HANDLE_W'({$urandom, $urandom});
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Walk one slot through every phase and each refused-handle path. Mostly
  // back-to-back, so the same slot is hit on consecutive cycles.
  task automatic test_directed_cases();
    send_request(FUNC_RESOLVE, '0, 1'b1);                             // none handle
    send_request(FUNC_ALLOC, '0, 1'b0);                               // slot 0, gen 0
    send_request(FUNC_RESOLVE, make_handle(0, GEN_W'(0)), 1'b0);      // pending refused
    send_request(FUNC_RESOLVE, make_handle(0, GEN_W'(0)), 1'b1);      // pending allowed
    send_request(FUNC_ADMIT, make_handle(0, GEN_W'(0)), 1'b0);
    send_request(FUNC_ADMIT, make_handle(0, GEN_W'(0)), 1'b0);        // already live
    send_request(FUNC_RESOLVE, make_handle(0, GEN_W'(0)), 1'b0);
    send_request(FUNC_DESTROY, make_handle(0, GEN_W'(0)), 1'b0);      // live -> doomed
    send_request(FUNC_DESTROY, make_handle(0, GEN_W'(0)), 1'b0);      // doomed twice
    send_request(FUNC_ADMIT, make_handle(0, GEN_W'(0)), 1'b1);        // doomed
    send_request(FUNC_RESOLVE, make_handle(0, GEN_W'(0)), 1'b1);      // doomed
    send_request(FUNC_RELEASE, make_handle(0, GEN_W'(0)), 1'b0);      // doomed release ok
    send_request(FUNC_RELEASE, make_handle(0, GEN_W'(0)), 1'b0);      // stale
    send_request(FUNC_RESOLVE, make_handle(0, GEN_W'(0)), 1'b1);      // stale
    send_request(FUNC_ALLOC, HANDLE_W'({$urandom, $urandom}), 1'b1);  // slot 0, gen 1
    send_request(FUNC_RELEASE, make_handle(0, GEN_W'(1)), 1'b0);      // pending release
    send_request(FUNC_ALLOC, '0, 1'b0);                               // slot 0, gen 2
    send_request(FUNC_ALLOC, '0, 1'b0);                               // slot 1, gen 0
    send_request(FUNC_ADMIT, make_handle(0, GEN_W'(2)), 1'b0);
    send_request(FUNC_RELEASE, make_handle(0, GEN_W'(2)), 1'b0);      // live release
    send_request(FUNC_DESTROY, make_handle(1, GEN_W'(0)), 1'b0);      // pending destroy
    for (logic [FUNC_W:0] f = {1'b0, FUNC_SPARE_FIRST}; f <= {1'b0, FUNC_SPARE_LAST}; f++)
      send_request(f[FUNC_W-1:0], make_handle(1, GEN_W'(0)), 1'b1);
    send_request(FUNC_RESOLVE, {GEN_W'(0), LOW_W'(SLOTS + 1)}, 1'b1); // index too big
    send_request(FUNC_RESOLVE, '1, 1'b1);
    send_request(FUNC_ADMIT, make_handle(SLOTS - 1, GEN_W'(0)), 1'b1); // last slot, free
  endtask

  // Empty the table, fill it past full, admit everything (count at its top),
  // doom some, then release all in a random order.
  task automatic test_fill_and_flush();
    int unsigned s;
    for (int i = 0; i < SLOTS; i++)
      if (slot_state[i] != PH_FREE) send_request(FUNC_RELEASE, make_handle(i, slot_gen[i]), 1'b0);
    no_gaps = 1'b1;
    for (int k = 0; k < SLOTS + 2; k++) begin
      if (k == SLOTS / 2) no_gaps = 1'b0;
      send_request(FUNC_ALLOC, HANDLE_W'({$urandom, $urandom}), 1'(($urandom)));
    end
    wait_drained();
    shuffle_order();
    for (int k = 0; k < SLOTS; k++) begin
      s = slot_order[k];
      send_request(FUNC_ADMIT, make_handle(s, slot_gen[s]), 1'(($urandom)));
    end
    send_request(FUNC_ALLOC, '0, 1'b0); // full with every slot live
    for (int k = 0; k < SLOTS / 4; k++) begin
      s = $urandom_range(SLOTS - 1);
      send_request(FUNC_DESTROY, make_handle(s, slot_gen[s]), 1'b0);
    end
    shuffle_order();
    no_gaps = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      if (k == SLOTS / 2) no_gaps = 1'b0;
      s = slot_order[k];
      send_request(FUNC_RELEASE, make_handle(s, slot_gen[s]), 1'b0);
    end
  endtask

  // Mixed traffic. The allocate share changes every hundred requests so the
  // table swings between nearly empty and full; some stretches run without
  // gaps and the sender drains now and then.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned r;
    int unsigned alloc_share;
    logic [FUNC_W-1:0] fn;
    alloc_share = 25;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 100 == 0) begin
        no_gaps = ($urandom_range(3) == 0);
        alloc_share = $urandom_range(8, 40);
      end
      if (k % 250 == 249) wait_drained();
      r = $urandom_range(99);
      if (r < alloc_share) fn = FUNC_ALLOC;
      else if (r < alloc_share + 18) fn = FUNC_ADMIT;
      else if (r < alloc_share + 28) fn = FUNC_DESTROY;
      else if (r < alloc_share + 50) fn = FUNC_RELEASE;
      else if (r < alloc_share + 54) fn = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
      else fn = FUNC_RESOLVE;
      send_request(fn, pick_handle(), 1'(($urandom)));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    func_i          = '0;
    handle_i        = '0;
    allow_pending_i = 1'b0;
    reset_table_model();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    wait_drained();
    test_fill_and_flush();
    wait_drained();
    test_random_traffic(RANDOM_ITEMS);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Requests: %0d allocate, %0d destroy, %0d release, %0d admit, %0d resolve, %0d spare",
             func_seen[FUNC_ALLOC], func_seen[FUNC_DESTROY], func_seen[FUNC_RELEASE],
             func_seen[FUNC_ADMIT], func_seen[FUNC_RESOLVE],
             func_seen[FUNC_SPARE_FIRST] + func_seen[FUNC_SPARE_FIRST + 1] +
             func_seen[FUNC_SPARE_LAST]);
    $display("Answers: %0d ok, %0d table full, %0d refused handle",
             ok_seen, full_seen, bad_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
